[rtl/core/lstk_pkg.sv]
// ----------------------------------------------------------------------------
// lstk_pkg
// Shared types and codes for the LIFO stack with running aggregates.
// ----------------------------------------------------------------------------
package lstk_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_SEARCH = 2'd3
    } req_t;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    // one stack entry with the aggregates of itself and everything below it
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] sum;
        logic signed [DATA_W-1:0] prod;
        logic signed [DATA_W-1:0] max;
        logic signed [DATA_W-1:0] min;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic search;
    } cell_ctl_t;

endpackage

[rtl/core/lstk_head.sv]
// ----------------------------------------------------------------------------
// lstk_head
// Builds the entry that a push places on top: new value plus prefix
// sum, product, maximum and minimum taken from the current top entry.
// ----------------------------------------------------------------------------
module lstk_head
(
    input  lstk_pkg::entry_t                       top,
    input  logic                                   empty,
    input  logic signed [lstk_pkg::DATA_W-1:0]     push_value,
    output lstk_pkg::entry_t                       fresh
);
    import lstk_pkg::*;

    logic [DATA_W-1:0] prod_lo;

    // low word of the product is sign independent
    assign prod_lo = DATA_W'(top.prod) * DATA_W'(push_value);

    always_comb
    begin
        fresh.value = push_value;
        if (empty)
        begin
            fresh.sum  = push_value;
            fresh.prod = push_value;
            fresh.max  = push_value;
            fresh.min  = push_value;
        end
        else
        begin
            fresh.sum  = top.sum + push_value;
            fresh.prod = signed'(prod_lo);
            fresh.max  = (push_value > top.max) ? push_value : top.max;
            fresh.min  = (push_value < top.min) ? push_value : top.min;
        end
    end

endmodule

[rtl/core/lstk_cell.sv]
// ----------------------------------------------------------------------------
// lstk_cell
// One stack slot. Takes its upper neighbour on push, its lower neighbour
// on pop, and compares its value against the search key.
// ----------------------------------------------------------------------------
module lstk_cell
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lstk_pkg::cell_ctl_t                    ctl,
    input  lstk_pkg::entry_t                       upper,
    input  lstk_pkg::entry_t                       lower,
    input  logic                                   occupied,
    input  logic signed [lstk_pkg::DATA_W-1:0]     search_key,
    output lstk_pkg::entry_t                       q,
    output logic                                   match
);
    import lstk_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   match_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push)
        begin
            entry_next = upper;
        end
        else if (ctl.pop)
        begin
            entry_next = lower;
        end
    end

    assign match_next = ctl.search && occupied && (entry_reg.value == search_key);

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign q     = entry_reg;
    assign match = match_reg;

endmodule

[rtl/core/lifo_stack_with_aggregates.sv]
// ----------------------------------------------------------------------------
// lifo_stack_with_aggregates
// Bounded LIFO stack of signed 32-bit words with running sum, product,
// maximum and minimum, built as a shifting chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req_type, push_value, search_key) is taken at a rising
//   edge with start high and busy low. busy is never raised: one word may
//   be issued every cycle.
//   Each request gives one result word, shown for one cycle with done high,
//   after it has passed the first-stage and second-stage registers. Results
//   come back in request order. Push and pop shift the whole chain by one
//   cell at once; the top of the stack is cell 0. Search compares every
//   held cell at once into a registered hit per cell, and the hits are ORed
//   into the output register; the per-cell hit register and the output
//   register lie between a search request and its result.
//   Reset clears the count and pending results; cell contents are left as
//   they are and are never read until written. No clearing pass is made.
//   The receiver cannot stall: done is never held off.
// ----------------------------------------------------------------------------
module lifo_stack_with_aggregates
#(
    parameter int unsigned STACK_DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             req_type,
    input  logic signed [lstk_pkg::DATA_W-1:0]     push_value,
    input  logic signed [lstk_pkg::DATA_W-1:0]     search_key,
    output logic                                   done,
    output logic signed [lstk_pkg::DATA_W-1:0]     popped_value,
    output logic                                   found,
    output logic signed [lstk_pkg::DATA_W-1:0]     top_value,
    output logic [lstk_pkg::COUNT_W-1:0]           entry_count,
    output logic                                   is_empty,
    output logic signed [lstk_pkg::DATA_W-1:0]     total_sum,
    output logic signed [lstk_pkg::DATA_W-1:0]     total_product,
    output logic signed [lstk_pkg::DATA_W-1:0]     max_value,
    output logic signed [lstk_pkg::DATA_W-1:0]     min_value,
    output logic [1:0]                             error_code
);
    import lstk_pkg::*;

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    logic                   accept;
    logic                   full;
    logic                   empty;
    cell_ctl_t              ctl;
    logic [1:0]             err_now;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    entry_t                 cell_q [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] hit;
    entry_t                 fresh;

    logic                   s1_valid_reg;
    logic signed [DATA_W-1:0] s1_popped_reg;
    logic [1:0]             s1_err_reg;

    logic                   done_reg;
    logic signed [DATA_W-1:0] popped_reg;
    logic                   found_reg;
    logic signed [DATA_W-1:0] top_reg;
    logic [COUNT_W-1:0]     count_out_reg;
    logic                   empty_reg;
    logic signed [DATA_W-1:0] sum_reg;
    logic signed [DATA_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic [1:0]             err_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        ctl        = '0;
        err_now    = ERR_OK;
        count_next = count_reg;
        if (accept)
        begin
            unique case (req_type)
                REQ_PUSH:
                begin
                    if (full)
                    begin
                        err_now = ERR_OVERFLOW;
                    end
                    else
                    begin
                        ctl.push   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_POP:
                begin
                    if (empty)
                    begin
                        err_now = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.pop    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                REQ_SEARCH:
                begin
                    ctl.search = 1'b1;
                end
                default:
                begin
                    ctl = '0;
                end
            endcase
        end
    end

    lstk_head u_head
    (
        .top        (cell_q[0]),
        .empty      (empty),
        .push_value (push_value),
        .fresh      (fresh)
    );

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        entry_t upper_w;
        entry_t lower_w;
        logic   occ_w;

        if (i == 0)
        begin : g_first
            assign upper_w = fresh;
        end
        else
        begin : g_mid
            assign upper_w = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign lower_w = cell_q[i];
        end
        else
        begin : g_inner
            assign lower_w = cell_q[i+1];
        end

        assign occ_w = (count_reg > CNT_W'(i));

        lstk_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .upper      (upper_w),
            .lower      (lower_w),
            .occupied   (occ_w),
            .search_key (search_key),
            .q          (cell_q[i]),
            .match      (hit[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    // first stage: pop word and error
    always_ff @(posedge clk)
    begin
        s1_popped_reg <= ctl.pop ? cell_q[0].value : '0;
        s1_err_reg    <= err_now;
    end

    // second stage: snapshot of the updated stack, with the pop word, error and search hit
    always_ff @(posedge clk)
    begin
        popped_reg    <= s1_popped_reg;
        found_reg     <= |hit;
        count_out_reg <= COUNT_W'(count_reg);
        empty_reg     <= empty;
        err_reg       <= s1_err_reg;
        if (empty)
        begin
            top_reg  <= '0;
            sum_reg  <= '0;
            prod_reg <= DATA_W'(1);
            max_reg  <= '0;
            min_reg  <= '0;
        end
        else
        begin
            top_reg  <= cell_q[0].value;
            sum_reg  <= cell_q[0].sum;
            prod_reg <= cell_q[0].prod;
            max_reg  <= cell_q[0].max;
            min_reg  <= cell_q[0].min;
        end
    end

    assign done          = done_reg;
    assign popped_value  = popped_reg;
    assign found         = found_reg;
    assign top_value     = top_reg;
    assign entry_count   = count_out_reg;
    assign is_empty      = empty_reg;
    assign total_sum     = sum_reg;
    assign total_product = prod_reg;
    assign max_value     = max_reg;
    assign min_value     = min_reg;
    assign error_code    = err_reg;

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result word missing two cycles after request");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(accept, 2))
        else $error("result word without a request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_empty_aggr: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_empty |-> total_product == DATA_W'(1) && top_value == '0)
        else $error("empty stack reports stale aggregates");

    a_pop_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not lower the count");

endmodule

[tb/lstk_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lstk_result_checker
// Watches the request and result channels of the aggregate LIFO stack, keeps
// its own copy of the stack with prefix sum, product, maximum and minimum,
// and compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lstk_result_checker
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic [1:0]                             req_type,
    input  logic signed [lstk_pkg::DATA_W-1:0]     push_value,
    input  logic signed [lstk_pkg::DATA_W-1:0]     search_key,
    input  logic                                   done,
    input  logic signed [lstk_pkg::DATA_W-1:0]     popped_value,
    input  logic                                   found,
    input  logic signed [lstk_pkg::DATA_W-1:0]     top_value,
    input  logic [lstk_pkg::COUNT_W-1:0]           entry_count,
    input  logic                                   is_empty,
    input  logic signed [lstk_pkg::DATA_W-1:0]     total_sum,
    input  logic signed [lstk_pkg::DATA_W-1:0]     total_product,
    input  logic signed [lstk_pkg::DATA_W-1:0]     max_value,
    input  logic signed [lstk_pkg::DATA_W-1:0]     min_value,
    input  logic [1:0]                             error_code,
    output int                                     fail_count,
    output int                                     outstanding,
    output int                                     checked,
    output int                                     search_hits,
    output int                                     overflows,
    output int                                     underflows
);

    typedef struct {
        logic signed [lstk_pkg::DATA_W-1:0] popped;
        logic                               hit;
        logic signed [lstk_pkg::DATA_W-1:0] top;
        logic [lstk_pkg::COUNT_W-1:0]       count;
        logic                               empty;
        logic signed [lstk_pkg::DATA_W-1:0] sum;
        logic signed [lstk_pkg::DATA_W-1:0] prod;
        logic signed [lstk_pkg::DATA_W-1:0] maxv;
        logic signed [lstk_pkg::DATA_W-1:0] minv;
        logic [1:0]                         err;
    } stack_result_t;

    logic signed [lstk_pkg::DATA_W-1:0] shadow_val  [DEPTH];
    logic signed [lstk_pkg::DATA_W-1:0] shadow_sum  [DEPTH];
    logic signed [lstk_pkg::DATA_W-1:0] shadow_prod [DEPTH];
    logic signed [lstk_pkg::DATA_W-1:0] shadow_max  [DEPTH];
    logic signed [lstk_pkg::DATA_W-1:0] shadow_min  [DEPTH];
    int                                 shadow_depth;

    stack_result_t pending_results[$];

    function automatic stack_result_t apply_request(
        lstk_pkg::req_t                     kind,
        logic signed [lstk_pkg::DATA_W-1:0] value,
        logic signed [lstk_pkg::DATA_W-1:0] key
    );
        stack_result_t r;
        int            n;
        r.popped = '0;
        r.hit    = 1'b0;
        r.err    = lstk_pkg::ERR_OK;
        case (kind)
            lstk_pkg::REQ_PUSH:
            begin
                if (shadow_depth >= DEPTH)
                begin
                    r.err = lstk_pkg::ERR_OVERFLOW;
                end
                else
                begin
                    n = shadow_depth;
                    shadow_val[n] = value;
                    if (n == 0)
                    begin
                        shadow_sum[n]  = value;
                        shadow_prod[n] = value;
                        shadow_max[n]  = value;
                        shadow_min[n]  = value;
                    end
                    else
                    begin
                        shadow_sum[n]  = shadow_sum[n-1] + value;
                        shadow_prod[n] = shadow_prod[n-1] * value;
                        shadow_max[n]  = (value > shadow_max[n-1]) ? value : shadow_max[n-1];
                        shadow_min[n]  = (value < shadow_min[n-1]) ? value : shadow_min[n-1];
                    end
                    shadow_depth = n + 1;
                end
            end
            lstk_pkg::REQ_POP:
            begin
                if (shadow_depth == 0)
                begin
                    r.err = lstk_pkg::ERR_UNDERFLOW;
                end
                else
                begin
                    shadow_depth = shadow_depth - 1;
                    r.popped = shadow_val[shadow_depth];
                end
            end
            lstk_pkg::REQ_CLEAR:
            begin
                shadow_depth = 0;
            end
            default:
            begin
                for (int i = 0; i < shadow_depth; i++)
                begin
                    if (shadow_val[i] == key)
                    begin
                        r.hit = 1'b1;
                    end
                end
            end
        endcase
        r.count = shadow_depth[lstk_pkg::COUNT_W-1:0];
        if (shadow_depth == 0)
        begin
            r.empty = 1'b1;
            r.top   = '0;
            r.sum   = '0;
            r.prod  = 1;
            r.maxv  = '0;
            r.minv  = '0;
        end
        else
        begin
            n = shadow_depth - 1;
            r.empty = 1'b0;
            r.top   = shadow_val[n];
            r.sum   = shadow_sum[n];
            r.prod  = shadow_prod[n];
            r.maxv  = shadow_max[n];
            r.minv  = shadow_min[n];
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t w;
        if (!rst_n)
        begin
            pending_results.delete();
            shadow_depth = 0;
            fail_count   = 0;
            outstanding  = 0;
            checked      = 0;
            search_hits  = 0;
            overflows    = 0;
            underflows   = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                w = apply_request(lstk_pkg::req_t'(req_type), push_value, search_key);
                if (w.hit)
                    search_hits++;
                if (w.err == lstk_pkg::ERR_OVERFLOW)
                    overflows++;
                if (w.err == lstk_pkg::ERR_UNDERFLOW)
                    underflows++;
                pending_results.push_back(w);
            end
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word with none expected, expected nothing, got count %0d",
                             $time, entry_count);
                end
                else
                begin
                    w = pending_results.pop_front();
                    checked++;
                    check_field("popped_value", w.popped, popped_value);
                    check_field("found", {31'b0, w.hit}, {31'b0, found});
                    check_field("top_value", w.top, top_value);
                    check_field("entry_count", {27'b0, w.count}, {27'b0, entry_count});
                    check_field("is_empty", {31'b0, w.empty}, {31'b0, is_empty});
                    check_field("total_sum", w.sum, total_sum);
                    check_field("total_product", w.prod, total_product);
                    check_field("max_value", w.maxv, max_value);
                    check_field("min_value", w.minv, min_value);
                    check_field("error_code", {30'b0, w.err}, {30'b0, error_code});
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the aggregate LIFO stack bench: directed corner requests followed
// by random bursts whose push bias swings between filling and draining.
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEMS       = 750;
    localparam int CYCLE_LIMIT = 200000;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic [1:0]                           req_type;
    logic signed [lstk_pkg::DATA_W-1:0]   push_value;
    logic signed [lstk_pkg::DATA_W-1:0]   search_key;
    logic                                 done;
    logic signed [lstk_pkg::DATA_W-1:0]   popped_value;
    logic                                 found;
    logic signed [lstk_pkg::DATA_W-1:0]   top_value;
    logic [lstk_pkg::COUNT_W-1:0]         entry_count;
    logic                                 is_empty;
    logic signed [lstk_pkg::DATA_W-1:0]   total_sum;
    logic signed [lstk_pkg::DATA_W-1:0]   total_product;
    logic signed [lstk_pkg::DATA_W-1:0]   max_value;
    logic signed [lstk_pkg::DATA_W-1:0]   min_value;
    logic [1:0]                           error_code;

    int fail_count;
    int outstanding;
    int checked;
    int search_hits;
    int overflows;
    int underflows;

    int                                 cycles = 0;
    int                                 sent[4];
    logic signed [lstk_pkg::DATA_W-1:0] recent[8];
    int                                 recent_wr;

    lifo_stack_with_aggregates #(.STACK_DEPTH(16)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .push_value    (push_value),
        .search_key    (search_key),
        .done          (done),
        .popped_value  (popped_value),
        .found         (found),
        .top_value     (top_value),
        .entry_count   (entry_count),
        .is_empty      (is_empty),
        .total_sum     (total_sum),
        .total_product (total_product),
        .max_value     (max_value),
        .min_value     (min_value),
        .error_code    (error_code)
    );

    lstk_result_checker #(.DEPTH(16)) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .push_value    (push_value),
        .search_key    (search_key),
        .done          (done),
        .popped_value  (popped_value),
        .found         (found),
        .top_value     (top_value),
        .entry_count   (entry_count),
        .is_empty      (is_empty),
        .total_sum     (total_sum),
        .total_product (total_product),
        .max_value     (max_value),
        .min_value     (min_value),
        .error_code    (error_code),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked       (checked),
        .search_hits   (search_hits),
        .overflows     (overflows),
        .underflows    (underflows)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_word(lstk_pkg::req_t kind,
                             logic signed [lstk_pkg::DATA_W-1:0] value,
                             logic signed [lstk_pkg::DATA_W-1:0] key);
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= kind;
        push_value <= value;
        search_key <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent[int'(kind)]++;
        if (kind == lstk_pkg::REQ_PUSH)
        begin
            recent[recent_wr] = value;
            recent_wr = (recent_wr + 1) % 8;
        end
    endtask

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [lstk_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 0;
            3:       return -1;
            4, 5:    return int'($urandom_range(0, 6)) - 3;
            6, 7:    return recent[$urandom_range(0, 7)];
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int seg_left;
        int burst_left;
        int push_bias;
        int roll;
        start      = 1'b0;
        req_type   = lstk_pkg::REQ_PUSH;
        push_value = '0;
        search_key = '0;
        rst_n      = 1'b0;
        recent_wr  = 0;
        seg_left   = 0;
        burst_left = 0;
        push_bias  = 50;
        foreach (sent[i])
            sent[i] = 0;
        foreach (recent[i])
            recent[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // empty-stack cases, extremes, fill to overflow, then clear and underflow
        send_word(lstk_pkg::REQ_POP, 32'sd11, 32'sd0);
        send_word(lstk_pkg::REQ_SEARCH, 32'sd0, 32'sd0);
        send_word(lstk_pkg::REQ_PUSH, 32'sh7fffffff, 32'sd0);
        send_word(lstk_pkg::REQ_PUSH, 32'sh80000000, 32'sd0);
        send_word(lstk_pkg::REQ_PUSH, -32'sd1, 32'sd0);
        send_word(lstk_pkg::REQ_PUSH, 32'sd0, 32'sd0);
        send_word(lstk_pkg::REQ_SEARCH, 32'sd0, 32'sh80000000);
        send_word(lstk_pkg::REQ_SEARCH, 32'sd0, 32'sd1);
        send_word(lstk_pkg::REQ_POP, 32'sd0, 32'sd0);
        for (int i = 0; i < 13; i++)
            send_word(lstk_pkg::REQ_PUSH, (i % 2) ? -(i + 2) : (i + 2), 32'sd0);
        send_word(lstk_pkg::REQ_PUSH, 32'sd5, 32'sd0);
        send_word(lstk_pkg::REQ_SEARCH, 32'sd0, 32'sh7fffffff);
        send_word(lstk_pkg::REQ_CLEAR, 32'sd0, 32'sd0);
        send_word(lstk_pkg::REQ_POP, 32'sd0, 32'sd0);
        drain_results();

        for (int k = 0; k < ITEMS; k++)
        begin
            if (seg_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_bias = 90;
                    1:       push_bias = 55;
                    default: push_bias = 25;
                endcase
                seg_left = $urandom_range(8, 48);
            end
            seg_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 5));
            end
            burst_left--;
            if (k == ITEMS / 2)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send_word(lstk_pkg::REQ_CLEAR, $urandom, $urandom);
            else if (roll < 22)
                send_word(lstk_pkg::REQ_SEARCH, $urandom, pick_value());
            else if (roll < 22 + push_bias * 78 / 100)
                send_word(lstk_pkg::REQ_PUSH, pick_value(), $urandom);
            else
                send_word(lstk_pkg::REQ_POP, $urandom, $urandom);
        end

        drain_results();
        repeat (8) @(negedge clk);

        $display("tb: %0d requests (push %0d, pop %0d, clear %0d, search %0d), %0d words checked",
                 sent[0] + sent[1] + sent[2] + sent[3], sent[0], sent[1], sent[2], sent[3],
                 checked);
        $display("tb: %0d search hits, %0d overflow and %0d underflow errors exercised",
                 search_hits, overflows, underflows);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
